[rtl/bpq_pkg.sv]
// Package for the button press qualifier: constants, codes and link types.
package bpq_pkg;

    localparam int NumButtons   = 4;
    localparam int ButtonIdxW   = 2;
    localparam int TimeW        = 32;
    localparam int DelayW       = 16;

    localparam logic [DelayW-1:0] RearmDelayReset = 16'd15;

    // Input word kinds carried on tuser
    localparam logic CmdSample = 1'b0;
    localparam logic CmdTake   = 1'b1;

    // Packed widths of the stream words
    localparam int InDataW  = 40;   // levels + now_ms, padded to bytes
    localparam int OutDataW = 40;   // pending, button, time, accepted, locks

    // Common control fanned out to every cell
    typedef struct packed {
        logic                  sample;
        logic                  holder_full;
        logic [NumButtons-1:0] levels;
        logic [TimeW-1:0]      now_ms;
        logic [DelayW-1:0]     rearm_delay;
    } cell_ctl_t;

    // Link handed from one cell to the next higher one
    typedef struct packed {
        logic fall_seen;
    } cell_link_t;

endpackage

[rtl/button_press_qualifier_top.sv]
// Top level of the button press qualifier: cell chain, event holder, output register.
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tdata: levels, now_ms; tuser: cmd
//  m_      | out | m_tvalid/m_tready  | tdata: pending, button, time, accepted, locks
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data: rearm_delay
//
// One word per cycle while s_tready is high; its result shows in the next cycle.
// The four cells decide in the same cycle; the falling-edge priority ripples
// through the cell links. Reset (aresetn low, synchronous) releases all buttons,
// clears locks, release times and the holder, and sets rearm_delay to 15.
// s_tready is low only while a result waits in the output register and m_tready is low.
module button_press_qualifier_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] levels, [35:4] now_ms, [39:36] zero
    input  logic [bpq_pkg::InDataW-1:0]   s_tdata,
    // [0] cmd
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] event_pending, [2:1] event_button, [34:3] event_time,
    // [35] accepted_now, [39:36] locked_buttons
    output logic [bpq_pkg::OutDataW-1:0]  m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [bpq_pkg::DelayW-1:0]    cfg_wr_data
);

    logic                                 s_accept;
    logic                                 take;
    logic [bpq_pkg::DelayW-1:0]           rearm_delay_reg;
    bpq_pkg::cell_ctl_t                   ctl;
    bpq_pkg::cell_link_t                  links [bpq_pkg::NumButtons+1];
    logic [bpq_pkg::NumButtons-1:0]       grants;
    logic [bpq_pkg::NumButtons-1:0]       locks_next;
    logic [bpq_pkg::ButtonIdxW-1:0]       grant_idx;
    logic                                 any_grant;

    logic                                 hold_full_reg, hold_full_next;
    logic [bpq_pkg::ButtonIdxW-1:0]       hold_btn_reg, hold_btn_next;
    logic [bpq_pkg::TimeW-1:0]            hold_time_reg, hold_time_next;

    logic                                 m_valid_reg;
    logic [bpq_pkg::OutDataW-1:0]         m_data_reg;

    assign s_tready = ~m_valid_reg | m_tready;
    assign s_accept = s_tvalid & s_tready;
    assign take     = s_accept & (s_tuser == bpq_pkg::CmdTake);

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rearm_delay_reg <= bpq_pkg::RearmDelayReset;
        end else if (cfg_wr_en) begin
            rearm_delay_reg <= cfg_wr_data;
        end
    end

    // Control shared by all cells
    assign ctl.sample      = s_accept & (s_tuser == bpq_pkg::CmdSample);
    assign ctl.holder_full = hold_full_reg;
    assign ctl.levels      = s_tdata[bpq_pkg::NumButtons-1:0];
    assign ctl.now_ms      = s_tdata[bpq_pkg::NumButtons +: bpq_pkg::TimeW];
    assign ctl.rearm_delay = rearm_delay_reg;

    assign links[0].fall_seen = 1'b0;

    // Chain of button cells, lowest index first
    for (genvar i = 0; i < bpq_pkg::NumButtons; i++) begin : g_cell
        bpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .level     (ctl.levels[i]),
            .link_in   (links[i]),
            .link_out  (links[i+1]),
            .grant     (grants[i]),
            .lock_next (locks_next[i])
        );
    end

    // At most one grant; encode its index
    always_comb begin
        grant_idx = '0;
        for (int i = 0; i < bpq_pkg::NumButtons; i++) begin
            if (grants[i]) begin
                grant_idx = grant_idx | bpq_pkg::ButtonIdxW'(i);
            end
        end
    end
    assign any_grant = |grants;

    // Event holder
    always_comb begin
        hold_full_next = hold_full_reg;
        hold_btn_next  = hold_btn_reg;
        hold_time_next = hold_time_reg;
        if (take) begin
            hold_full_next = 1'b0;
            hold_btn_next  = '0;
            hold_time_next = '0;
        end else if (any_grant) begin
            hold_full_next = 1'b1;
            hold_btn_next  = grant_idx;
            hold_time_next = ctl.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_full_reg <= 1'b0;
            hold_btn_reg  <= '0;
            hold_time_reg <= '0;
        end else begin
            hold_full_reg <= hold_full_next;
            hold_btn_reg  <= hold_btn_next;
            hold_time_reg <= hold_time_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {locks_next, any_grant, hold_time_next, hold_btn_next,
                           hold_full_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A new event always leaves the holder full
    a_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35] |-> m_tdata[0])
        else $error("accepted_now without event_pending");

    // Only one cell may win a sample
    a_one_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(grants))
        else $error("more than one cell granted");

    // A take empties the holder
    a_take_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> !hold_full_reg)
        else $error("holder still full after take");

    // A full holder blocks every grant
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_full_reg |-> grants == '0)
        else $error("grant while holder full");

endmodule

[rtl/bpq_cell.sv]
// One button cell: previous level, lock bit and release time for one button.
module bpq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpq_pkg::cell_ctl_t  ctl,
    input  logic                level,
    input  bpq_pkg::cell_link_t link_in,
    output bpq_pkg::cell_link_t link_out,
    output logic                grant,
    output logic                lock_next
);

    logic                          prev_reg, prev_next;
    logic                          lock_reg;
    logic [bpq_pkg::TimeW-1:0]     rel_reg, rel_next;
    logic [bpq_pkg::TimeW-1:0]     elapsed;
    logic                          fall, rise, delay_ok;

    // Edge detect against the previous sample
    assign fall = prev_reg & ~level;
    assign rise = ~prev_reg & level;

    // Wrapping elapsed time since the last release
    assign elapsed  = ctl.now_ms - rel_reg;
    assign delay_ok = elapsed >= {{(bpq_pkg::TimeW-bpq_pkg::DelayW){1'b0}}, ctl.rearm_delay};

    // Only the lowest falling edge may win; cells above see it through the link
    assign grant = ctl.sample & fall & ~link_in.fall_seen & ~lock_reg
                   & delay_ok & ~ctl.holder_full;
    assign link_out.fall_seen = link_in.fall_seen | fall;

    // Release clears the lock after the press decision
    always_comb begin
        lock_next = lock_reg;
        rel_next  = rel_reg;
        prev_next = prev_reg;
        if (ctl.sample) begin
            prev_next = level;
            if (rise) begin
                lock_next = 1'b0;
                rel_next  = ctl.now_ms;
            end else if (grant) begin
                lock_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= 1'b1;
            lock_reg <= 1'b0;
            rel_reg  <= '0;
        end else begin
            prev_reg <= prev_next;
            lock_reg <= lock_next;
            rel_reg  <= rel_next;
        end
    end

endmodule

[test/bpq_event_checker.sv]
// Event checker for the button press qualifier: predicts each result word and compares it.
`timescale 1ns / 100ps
module bpq_event_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [3:0] levels, [35:4] now_ms, [39:36] zero
    input  logic [bpq_pkg::InDataW-1:0]   s_tdata,
    // [0] cmd
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] event_pending, [2:1] event_button, [34:3] event_time,
    // [35] accepted_now, [39:36] locked_buttons
    input  logic [bpq_pkg::OutDataW-1:0]  m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [bpq_pkg::DelayW-1:0]    cfg_wr_data,
    output int                            fail_count,
    output int                            outstanding
);

    typedef struct packed {
        logic                           pending;
        logic [bpq_pkg::ButtonIdxW-1:0] button;
        logic [bpq_pkg::TimeW-1:0]      stamp;
        logic                           accepted;
        logic [bpq_pkg::NumButtons-1:0] locks;
    } press_result_t;

    // Shadow copy of the qualifier state
    logic [bpq_pkg::DelayW-1:0]     rearm_delay;
    logic [bpq_pkg::NumButtons-1:0] prev_levels;
    logic [bpq_pkg::NumButtons-1:0] lock_bits;
    logic [bpq_pkg::TimeW-1:0]      release_time [bpq_pkg::NumButtons];
    logic                           holder_full;
    logic [bpq_pkg::ButtonIdxW-1:0] holder_button;
    logic [bpq_pkg::TimeW-1:0]      holder_time;

    press_result_t awaited_events [$];
    press_result_t want;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    // Apply one input word to the shadow state and return the word it should produce
    function automatic press_result_t qualify_word(logic cmd,
                                                   logic [bpq_pkg::NumButtons-1:0] lv,
                                                   logic [bpq_pkg::TimeW-1:0] now);
        logic [bpq_pkg::NumButtons-1:0] changed;
        logic [bpq_pkg::NumButtons-1:0] falling;
        logic [bpq_pkg::NumButtons-1:0] rising;
        logic [bpq_pkg::TimeW-1:0]      elapsed;
        press_result_t                  res;
        int                             pick;
        res.accepted = 1'b0;
        pick = -1;
        if (cmd == bpq_pkg::CmdTake) begin
            holder_full   = 1'b0;
            holder_button = '0;
            holder_time   = '0;
        end else begin
            changed = lv ^ prev_levels;
            falling = ~lv & changed;
            rising  = lv & changed;
            // lowest-numbered falling edge wins
            for (int b = bpq_pkg::NumButtons - 1; b >= 0; b--) begin
                if (falling[b]) pick = b;
            end
            if (pick >= 0) begin
                elapsed = now - release_time[pick];
                if (!lock_bits[pick] && elapsed >= bpq_pkg::TimeW'(rearm_delay)
                    && !holder_full) begin
                    holder_full     = 1'b1;
                    holder_button   = bpq_pkg::ButtonIdxW'(pick);
                    holder_time     = now;
                    lock_bits[pick] = 1'b1;
                    res.accepted    = 1'b1;
                end
            end
            // releases land after the press decision
            for (int b = 0; b < bpq_pkg::NumButtons; b++) begin
                if (rising[b]) begin
                    lock_bits[b]    = 1'b0;
                    release_time[b] = now;
                end
            end
            prev_levels = lv;
        end
        res.pending = holder_full;
        res.button  = holder_full ? holder_button : '0;
        res.stamp   = holder_full ? holder_time : '0;
        res.locks   = lock_bits;
        return res;
    endfunction

    task automatic check_field(string name, logic [bpq_pkg::TimeW-1:0] exp_val,
                               logic [bpq_pkg::TimeW-1:0] got);
        if (got !== exp_val) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rearm_delay   = bpq_pkg::RearmDelayReset;
            prev_levels   = '1;
            lock_bits     = '0;
            holder_full   = 1'b0;
            holder_button = '0;
            holder_time   = '0;
            for (int b = 0; b < bpq_pkg::NumButtons; b++) release_time[b] = '0;
            awaited_events.delete();
        end else begin
            if (cfg_wr_en) rearm_delay = cfg_wr_data;
            // result word leaving the block
            if (m_tvalid && m_tready) begin
                if (awaited_events.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none, actual %0h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_events.pop_front();
                    check_field("event_pending", bpq_pkg::TimeW'(want.pending),
                                bpq_pkg::TimeW'(m_tdata[0]));
                    check_field("event_button", bpq_pkg::TimeW'(want.button),
                                bpq_pkg::TimeW'(m_tdata[2:1]));
                    check_field("event_time", want.stamp, m_tdata[34:3]);
                    check_field("accepted_now", bpq_pkg::TimeW'(want.accepted),
                                bpq_pkg::TimeW'(m_tdata[35]));
                    check_field("locked_buttons", bpq_pkg::TimeW'(want.locks),
                                bpq_pkg::TimeW'(m_tdata[39:36]));
                end
            end
            // input word entering the block
            if (s_tvalid && s_tready)
                awaited_events.push_back(qualify_word(s_tuser, s_tdata[3:0], s_tdata[35:4]));
        end
        outstanding = awaited_events.size();
    end

endmodule

[test/button_press_qualifier_top_test.sv]
// Testbench top for the button press qualifier: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module button_press_qualifier_top_test;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bpq_pkg::InDataW-1:0]    s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bpq_pkg::OutDataW-1:0]   m_tdata;
    logic                           cfg_wr_en;
    logic [bpq_pkg::DelayW-1:0]     cfg_wr_data;
    int                             fail_count;
    int                             outstanding;

    int                             idle_pct;
    int                             stall_pct;
    int                             last_bit;
    logic [bpq_pkg::NumButtons-1:0] cur_levels;
    logic [bpq_pkg::TimeW-1:0]      cur_now;
    logic [bpq_pkg::DelayW-1:0]     cur_delay;

    button_press_qualifier_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bpq_event_checker event_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Offer one word after a random gap, hold it until it is taken
    task automatic send_word(logic cmd, logic [bpq_pkg::NumButtons-1:0] lv,
                             logic [bpq_pkg::TimeW-1:0] now);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= bpq_pkg::InDataW'({now, lv});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stop offering and let every expected word come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_delay(logic [bpq_pkg::DelayW-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_delay    = value;
    endtask

    // Mostly press/release sequences with time steps near the rearm delay,
    // mixed with takes and random noise samples
    task automatic run_random(int count);
        logic [bpq_pkg::NumButtons-1:0] flip;
        logic [bpq_pkg::TimeW-1:0]      step;
        int                             roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
                send_word(bpq_pkg::CmdTake, bpq_pkg::NumButtons'($urandom), $urandom);
            end else if (roll < 27) begin
                cur_levels = bpq_pkg::NumButtons'($urandom);
                cur_now    = $urandom;
                send_word(bpq_pkg::CmdSample, cur_levels, cur_now);
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    flip = bpq_pkg::NumButtons'($urandom_range(1, 15));
                end else begin
                    if ($urandom_range(0, 1) == 0)
                        last_bit = $urandom_range(0, bpq_pkg::NumButtons - 1);
                    flip = bpq_pkg::NumButtons'(1) << last_bit;
                end
                cur_levels ^= flip;
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    step = $urandom_range(0, 32'(cur_delay) * 2 + 3);
                else if (roll == 7)
                    step = 32'(cur_delay);
                else if (roll == 8)
                    step = 32'(cur_delay) - 1;
                else
                    step = '0;
                cur_now += step;
                send_word(bpq_pkg::CmdSample, cur_levels, cur_now);
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = bpq_pkg::CmdSample;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        last_bit    = 0;
        cur_levels  = '1;
        cur_now     = '0;
        cur_delay   = bpq_pkg::RearmDelayReset;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: first press, press while holder full, takes, multi-edge
        send_word(bpq_pkg::CmdSample, 4'hF, 32'd100);
        send_word(bpq_pkg::CmdSample, 4'hE, 32'd101);
        send_word(bpq_pkg::CmdSample, 4'hC, 32'd102);
        send_word(bpq_pkg::CmdTake,   4'h0, 32'h0);
        send_word(bpq_pkg::CmdTake,   4'hF, 32'hFFFF_FFFF);
        send_word(bpq_pkg::CmdSample, 4'h0, 32'd103);
        send_word(bpq_pkg::CmdSample, 4'hF, 32'd200);
        send_word(bpq_pkg::CmdTake,   4'h5, 32'hA5A5_5A5A);
        // rearm delay: too early, then exactly on the boundary
        send_word(bpq_pkg::CmdSample, 4'hE, 32'd205);
        send_word(bpq_pkg::CmdSample, 4'hF, 32'd210);
        send_word(bpq_pkg::CmdSample, 4'hE, 32'd225);
        send_word(bpq_pkg::CmdTake,   4'h0, 32'hFFFF_FFFF);
        // elapsed time across the 32-bit wrap
        send_word(bpq_pkg::CmdSample, 4'hF, 32'hFFFF_FFF5);
        send_word(bpq_pkg::CmdSample, 4'hE, 32'h0000_0004);
        send_word(bpq_pkg::CmdTake,   4'hA, 32'd0);
        send_word(bpq_pkg::CmdSample, 4'hF, 32'd5);
        send_word(bpq_pkg::CmdSample, 4'hE, 32'd19);
        send_word(bpq_pkg::CmdSample, 4'hF, 32'd20);
        send_word(bpq_pkg::CmdSample, 4'h7, 32'd0);
        send_word(bpq_pkg::CmdTake,   4'hF, 32'd0);
        send_word(bpq_pkg::CmdSample, 4'h0, 32'hFFFF_FFFF);
        send_word(bpq_pkg::CmdSample, 4'hF, 32'hFFFF_FFFF);
        send_word(bpq_pkg::CmdTake,   4'hF, 32'hFFFF_FFFF);

        // random phases over delay settings and idling patterns
        for (int blk = 0; blk < 8; blk++) begin
            case (blk)
                1: write_delay(16'd0);
                2: write_delay(16'hFFFF);
                3: write_delay(bpq_pkg::DelayW'($urandom));
                4: write_delay(16'd1);
                5: write_delay(bpq_pkg::DelayW'($urandom_range(2, 60)));
                6: write_delay(16'hFFFE);
                7: write_delay(bpq_pkg::RearmDelayReset);
                default: ;
            endcase
            idle_pct  = (blk % 4 == 1) ? 81 : (blk % 4 == 3) ? 38 : 0;
            stall_pct = (blk % 4 == 2) ? 81 : (blk % 4 == 3) ? 38 : 0;
            run_random(140);
        end

        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
